// File: hdl/mrcp_pkg.sv
// shared types and command codes for the matrix row/column permute engine
// no dependencies
package mrcp_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_SWAP_ROW = 3'd1,
    CMD_SWAP_COL = 3'd2,
    CMD_DIAG     = 3'd3,
    CMD_ROT_ROW  = 3'd4,
    CMD_ROT_COL  = 3'd5,
    CMD_READ     = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_e;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_ROWS = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_COLS = 1'b1;
  localparam int unsigned SizeW = 5;
  localparam int unsigned IdxW  = 4;

  // controller to datapath
  typedef struct packed {
    logic       rd_en;     // read address issued
    logic [7:0] rd_row;
    logic [7:0] rd_col;
    logic       wr_en;
    logic [7:0] wr_row;
    logic [7:0] wr_col;
    logic [1:0] wr_sel;    // 0 value, 1 read data, 2 held word
    logic       hold_en;   // capture read data into the held word
  } dp_cmd_t;

  localparam logic [1:0] WSEL_VALUE = 2'd0;
  localparam logic [1:0] WSEL_RDATA = 2'd1;
  localparam logic [1:0] WSEL_HOLD  = 2'd2;

endpackage

// File: hdl/mrcp_if.sv
// valid/ready channel interfaces for input words, result words and config writes
// no dependencies
interface mrcp_in_if #(parameter int DATA_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    command;
  logic [3:0]                    index_a;
  logic [3:0]                    index_b;
  logic signed [DATA_WIDTH-1:0]  value;
  logic                          direction;
  modport source (output valid, command, index_a, index_b, value, direction, input ready);
  modport sink   (input valid, command, index_a, index_b, value, direction, output ready);
endinterface

interface mrcp_out_if #(parameter int DATA_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  read_value;
  logic                          index_error;
  modport source (output valid, read_value, index_error, input ready);
  modport sink   (input valid, read_value, index_error, output ready);
endinterface

interface mrcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/mrcp_datapath.sv
// matrix store memory with one write and one registered read port, plus a held word
// depends on mrcp_pkg
module mrcp_datapath #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  mrcp_pkg::dp_cmd_t     cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);
  import mrcp_pkg::*;

  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DATA_WIDTH-1:0] mem_q [Depth];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] hold_q;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AddrW-1:0]      waddr;
  logic [AddrW-1:0]      raddr;

  function automatic logic [AddrW-1:0] addr_of(input logic [7:0] r, input logic [7:0] c);
    logic [2*AddrW+1:0] a;
    a = (2*AddrW+2)'(r[RowW-1:0]) * (2*AddrW+2)'(MAX_COLS) + (2*AddrW+2)'(c[ColW-1:0]);
    return a[AddrW-1:0];
  endfunction

  assign waddr = addr_of(cmd_i.wr_row, cmd_i.wr_col);
  assign raddr = addr_of(cmd_i.rd_row, cmd_i.rd_col);

  always_comb begin
    unique case (cmd_i.wr_sel)
      WSEL_RDATA: wdata = rdata_q;
      WSEL_HOLD:  wdata = hold_q;
      default:    wdata = value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (cmd_i.hold_en) begin
      hold_q <= rdata_q;
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: hdl/mrcp_ctrl.sv
// command sequencer: range check, loads and reads, element walks for swaps, rotations and fills
// depends on mrcp_pkg
module mrcp_ctrl #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                command_i,
  input  logic [3:0]                index_a_i,
  input  logic [3:0]                index_b_i,
  input  logic [DATA_WIDTH-1:0]     value_i,
  input  logic                      direction_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DATA_WIDTH-1:0]     read_value_o,
  output logic                      index_error_o,
  input  logic [mrcp_pkg::SizeW-1:0] rows_i,
  input  logic [mrcp_pkg::SizeW-1:0] cols_i,
  output mrcp_pkg::dp_cmd_t         dp_cmd_o,
  output logic [DATA_WIDTH-1:0]     dp_value_o,
  input  logic [DATA_WIDTH-1:0]     dp_rdata_i
);
  import mrcp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SWAP, S_ROT, S_DIAG, S_READ, S_RESULT
  } state_e;

  state_e           state_q;
  cmd_e             cmd_q;
  logic [7:0]       a_q, b_q;
  logic             dir_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [8:0]       nr, nc;
  logic [8:0]       len_q;   // elements along the walk
  logic [8:0]       i_q;     // walk step
  logic [1:0]       ph_q;    // phase within one step
  logic             out_valid_q;
  logic [DATA_WIDTH-1:0] out_val_q;
  logic             out_err_q;
  logic             bad;
  cmd_e             cmd_in;
  logic [8:0]       ain, bin;
  logic signed [10:0] d, c1, c2;
  logic [8:0]       nxt;
  dp_cmd_t          dc;

  localparam logic [8:0] MaxR = 9'(MAX_ROWS);
  localparam logic [8:0] MaxC = 9'(MAX_COLS);

  always_comb begin
    nr = (rows_i == '0) ? 9'd1 : ((9'(rows_i) > MaxR) ? MaxR : 9'(rows_i));
    nc = (cols_i == '0) ? 9'd1 : ((9'(cols_i) > MaxC) ? MaxC : 9'(cols_i));
  end

  assign cmd_in = cmd_e'(command_i);
  assign ain = 9'(index_a_i);
  assign bin = 9'(index_b_i);

  always_comb begin
    unique case (cmd_in)
      CMD_LOAD, CMD_DIAG, CMD_READ: bad = (ain >= nr) || (bin >= nc);
      CMD_SWAP_ROW: bad = (ain >= nr) || (bin >= nr);
      CMD_SWAP_COL: bad = (ain >= nc) || (bin >= nc);
      CMD_ROT_ROW:  bad = (ain >= nr);
      CMD_ROT_COL:  bad = (ain >= nc);
      default:      bad = 1'b0;
    endcase
  end

  // ready when idle and no result waits
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;

  // diagonal columns for row i_q
  assign d  = 11'(i_q) - 11'(a_q);
  assign c1 = 11'(b_q) + d;
  assign c2 = 11'(b_q) - d;
  assign nxt = i_q + 9'd1;

  // rotation index: position being written at step i
  // dir 1: write pos i from pos i+1 (i from 0..len-2), final pos len-1 from held
  // dir 0: write pos len-1-i from pos len-2-i, final pos 0 from held
  logic [8:0] wpos, rpos;
  always_comb begin
    if (dir_q) begin
      wpos = i_q;
      rpos = nxt;
    end else begin
      wpos = len_q - 9'd1 - i_q;
      rpos = len_q - 9'd2 - i_q;
    end
  end

  function automatic void place(input logic col_walk, input logic [7:0] fixed,
                                input logic [7:0] pos, output logic [7:0] r,
                                output logic [7:0] c);
    if (col_walk) begin
      r = pos;
      c = fixed;
    end else begin
      r = fixed;
      c = pos;
    end
  endfunction

  logic col_walk;
  assign col_walk = (cmd_q == CMD_ROT_COL) || (cmd_q == CMD_SWAP_COL);

  always_comb begin
    logic [7:0] r0, c0;
    dc = '0;
    r0 = '0;
    c0 = '0;
    unique case (state_q)
      S_SWAP: begin
        // ph0 read a, ph1 read b/hold a, ph2 write a<=b, ph3 write b<=held
        unique case (ph_q)
          2'd0: begin
            place(col_walk, a_q, i_q[7:0], r0, c0);
            dc.rd_en = 1'b1; dc.rd_row = r0; dc.rd_col = c0;
          end
          2'd1: begin
            place(col_walk, b_q, i_q[7:0], r0, c0);
            dc.rd_en = 1'b1; dc.rd_row = r0; dc.rd_col = c0;
            dc.hold_en = 1'b1;
          end
          2'd2: begin
            place(col_walk, a_q, i_q[7:0], r0, c0);
            dc.wr_en = 1'b1; dc.wr_row = r0; dc.wr_col = c0; dc.wr_sel = WSEL_RDATA;
          end
          default: begin
            place(col_walk, b_q, i_q[7:0], r0, c0);
            dc.wr_en = 1'b1; dc.wr_row = r0; dc.wr_col = c0; dc.wr_sel = WSEL_HOLD;
          end
        endcase
      end
      S_ROT: begin
        // ph0 read first element, ph1 hold it; then ph2 read src, ph3 write dst
        unique case (ph_q)
          2'd0: begin
            place(col_walk, a_q, dir_q ? 8'd0 : 8'(len_q - 9'd1), r0, c0);
            dc.rd_en = 1'b1; dc.rd_row = r0; dc.rd_col = c0;
          end
          2'd1: dc.hold_en = 1'b1;
          2'd2: begin
            place(col_walk, a_q, rpos[7:0], r0, c0);
            dc.rd_en = 1'b1; dc.rd_row = r0; dc.rd_col = c0;
          end
          default: begin
            place(col_walk, a_q, wpos[7:0], r0, c0);
            dc.wr_en = 1'b1; dc.wr_row = r0; dc.wr_col = c0;
            dc.wr_sel = (i_q == len_q - 9'd1) ? WSEL_HOLD : WSEL_RDATA;
          end
        endcase
      end
      S_DIAG: begin
        dc.wr_row = i_q[7:0];
        dc.wr_sel = WSEL_VALUE;
        if (ph_q == 2'd0) begin
          dc.wr_en  = (c1 >= 0) && (c1 < 11'(nc));
          dc.wr_col = c1[7:0];
        end else begin
          dc.wr_en  = (c2 >= 0) && (c2 < 11'(nc));
          dc.wr_col = c2[7:0];
        end
      end
      S_READ: begin
        dc.rd_en = (ph_q == 2'd0);
        dc.rd_row = a_q;
        dc.rd_col = b_q;
      end
      default: ;
    endcase
    if (state_q == S_IDLE && in_valid_i && in_ready_o && !bad && cmd_in == CMD_LOAD) begin
      dc.wr_en = 1'b1; dc.wr_row = ain[7:0]; dc.wr_col = bin[7:0]; dc.wr_sel = WSEL_VALUE;
    end
  end

  assign dp_cmd_o   = dc;
  assign dp_value_o = (state_q == S_IDLE) ? value_i : val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_NONE;
      a_q         <= '0;
      b_q         <= '0;
      dir_q       <= 1'b0;
      len_q       <= '0;
      i_q         <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
      out_err_q   <= 1'b0;
      out_val_q   <= '0;
      val_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q <= cmd_in;
            a_q   <= ain[7:0];
            b_q   <= bin[7:0];
            dir_q <= direction_i;
            val_q <= value_i;
            i_q   <= '0;
            ph_q  <= '0;
            if (bad) begin
              out_valid_q <= 1'b1;
              out_err_q   <= 1'b1;
              out_val_q   <= '0;
            end else begin
              unique case (cmd_in)
                CMD_SWAP_ROW: begin
                  len_q <= nc;
                  state_q <= (ain == bin) ? S_IDLE : S_SWAP;
                end
                CMD_SWAP_COL: begin
                  len_q <= nr;
                  state_q <= (ain == bin) ? S_IDLE : S_SWAP;
                end
                CMD_ROT_ROW: begin
                  len_q <= nc;
                  state_q <= (nc == 9'd1) ? S_IDLE : S_ROT;
                end
                CMD_ROT_COL: begin
                  len_q <= nr;
                  state_q <= (nr == 9'd1) ? S_IDLE : S_ROT;
                end
                CMD_DIAG: begin
                  len_q <= nr;
                  state_q <= S_DIAG;
                end
                CMD_READ: state_q <= S_READ;
                default: ;
              endcase
            end
          end
        end
        S_SWAP: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd3) begin
            i_q <= nxt;
            if (nxt == len_q) state_q <= S_IDLE;
          end
        end
        S_ROT: begin
          unique case (ph_q)
            2'd0: ph_q <= 2'd1;
            2'd1: ph_q <= (len_q == 9'd2 && 1'b0) ? 2'd3 : 2'd2;
            2'd2: ph_q <= 2'd3;
            default: begin
              i_q <= nxt;
              if (i_q == len_q - 9'd1) begin
                state_q <= S_IDLE;
              end else if (nxt == len_q - 9'd1) begin
                ph_q <= 2'd3;   // final write from held word
              end else begin
                ph_q <= 2'd2;
              end
            end
          endcase
        end
        S_DIAG: begin
          ph_q <= {1'b0, ~ph_q[0]};
          if (ph_q[0]) begin
            i_q <= nxt;
            if (nxt == len_q) state_q <= S_IDLE;
          end
        end
        S_READ: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd1) begin
            out_valid_q <= 1'b1;
            out_err_q   <= 1'b0;
            out_val_q   <= dp_rdata_i;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_val_q;
  assign index_error_o = out_err_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input accepted while busy");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP || state_q == S_DIAG) |-> (i_q < len_q))
    else $error("walk index past length");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_val_q == '0))
    else $error("error result carries data");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_val_q))
    else $error("result dropped while stalled");
endmodule

// File: hdl/matrix_row_column_permute_engine.sv
// top level of the matrix row/column permute engine: config registers and hookup
// depends on mrcp_pkg, mrcp_if, mrcp_ctrl and mrcp_datapath
//
// Commands run one at a time through a single-port-write, single-read store of
// MAX_ROWS*MAX_COLS words. A load writes its word directly; a read returns one
// word; a row or column swap walks each element of the walked line; a rotation
// walks the line through a held word; a diagonal fill walks each in-use row.
// Errors return a word with index_error set and zero data.
// Size registers are taken at any time but should be written while idle;
// a size of 0 acts as 1 and a size above the maximum acts as the maximum.
module matrix_row_column_permute_engine #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrcp_in_if.sink    in_ch,
  mrcp_out_if.source out_ch,
  mrcp_cfg_if.sink   cfg_ch
);
  import mrcp_pkg::*;

  logic [SizeW-1:0]      rows_q, cols_q;
  dp_cmd_t               dp_cmd;
  logic [DATA_WIDTH-1:0] dp_value;
  logic [DATA_WIDTH-1:0] dp_rdata;
  logic [DATA_WIDTH-1:0] rv;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SizeW'(16);
      cols_q <= SizeW'(16);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROWS: rows_q <= cfg_ch.data;
        default:  cols_q <= cfg_ch.data;
      endcase
    end
  end

  mrcp_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .command_i    (in_ch.command),
    .index_a_i    (in_ch.index_a),
    .index_b_i    (in_ch.index_b),
    .value_i      (in_ch.value),
    .direction_i  (in_ch.direction),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .read_value_o (rv),
    .index_error_o(out_ch.index_error),
    .rows_i       (rows_q),
    .cols_i       (cols_q),
    .dp_cmd_o     (dp_cmd),
    .dp_value_o   (dp_value),
    .dp_rdata_i   (dp_rdata)
  );

  assign out_ch.read_value = rv;

  mrcp_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i,
    .cmd_i   (dp_cmd),
    .value_i (dp_value),
    .rdata_o (dp_rdata)
  );
endmodule
